### rtl/qfe_pkg.sv
// Shared types and constants for the GF(2) quadratic form evaluator.
`timescale 1ns / 1ps
package qfe_pkg;

    localparam int NUM_VARS_W   = 6;   // width of the num_vars register
    localparam int IDX_W        = 5;   // width of a variable index field
    localparam int VAR_W        = 32;  // width of the variable assignment field
    localparam int CMP_W        = 7;   // holds any count or index up to 64
    localparam int DEF_MAX_VARS = 32;
    localparam int NUM_VARS_RST = 32;

    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_FLIP = 2'd1,
        ACT_READ = 2'd2,
        ACT_EVAL = 2'd3
    } t_action;

    // control from the sequencer to the coefficient store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_store_ctl;

endpackage

### rtl/qfe_store.sv
// Coefficient row memory with per-row valid bits and a registered read port.
`timescale 1ns / 1ps
module qfe_store #(
    parameter int MAX_VARS = qfe_pkg::DEF_MAX_VARS,
    parameter int AW       = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qfe_pkg::t_store_ctl i_ctl,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [MAX_VARS-1:0] i_wr_data,
    output logic [MAX_VARS-1:0] o_rd_data
);
    import qfe_pkg::*;

    logic [MAX_VARS-1:0] mem_rows [MAX_VARS];
    logic [MAX_VARS-1:0] r_row_vld;
    logic [MAX_VARS-1:0] r_rd_raw;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem_rows[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_raw <= mem_rows[i_rd_addr];
        end
    end

    // a row never written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule

### rtl/qfe_ctrl.sv
// Sequencer: configuration, term read-modify-write and row-by-row evaluation.
`timescale 1ns / 1ps
module qfe_ctrl #(
    parameter int MAX_VARS = qfe_pkg::DEF_MAX_VARS,
    parameter int AW       = 5,
    parameter int CNT_W    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [qfe_pkg::NUM_VARS_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic                          i_const_sel,
    input  logic [qfe_pkg::IDX_W-1:0]     i_row_index,
    input  logic [qfe_pkg::IDX_W-1:0]     i_col_index,
    input  logic                          i_term_value,
    input  logic [qfe_pkg::VAR_W-1:0]     i_var_bits,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_bit,
    output logic                          o_ok,
    output qfe_pkg::t_store_ctl           o_ctl,
    output logic [AW-1:0]                 o_rd_addr,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [MAX_VARS-1:0]           o_wr_data,
    input  logic [MAX_VARS-1:0]           i_rd_data
);
    import qfe_pkg::*;

    localparam int RST_COUNT = (NUM_VARS_RST > MAX_VARS) ? MAX_VARS : NUM_VARS_RST;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TERM_RD,
        S_TERM_WR,
        S_EVAL,
        S_DONE
    } t_state;

    t_state              r_state;
    t_action             r_action;
    logic [AW-1:0]       r_lo;
    logic [AW-1:0]       r_hi;
    logic                r_tv;
    logic [MAX_VARS-1:0] r_x;
    logic [CNT_W-1:0]    r_j;
    logic [AW-1:0]       r_jd;
    logic                r_pend;
    logic                r_acc;
    logic                r_res;
    logic                r_ok;
    logic                r_const;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;
    logic                r_out_res;
    logic                r_out_ok;

    t_action             in_act;
    logic                idx_ok;
    logic [IDX_W-1:0]    in_lo;
    logic [IDX_W-1:0]    in_hi;
    logic [MAX_VARS-1:0] lo_bit;
    logic [MAX_VARS-1:0] row_mask;
    logic                acc_next;
    logic                eval_more;
    logic                out_free;
    logic [CNT_W-1:0]    cfg_count;

    assign in_act  = t_action'(i_action);
    assign idx_ok  = (CMP_W'(i_row_index) < CMP_W'(r_count))
                  && (CMP_W'(i_col_index) < CMP_W'(r_count));
    assign in_lo   = (i_row_index < i_col_index) ? i_row_index : i_col_index;
    assign in_hi   = (i_row_index < i_col_index) ? i_col_index : i_row_index;
    assign lo_bit  = MAX_VARS'(1) << r_lo;
    // bits 0..jd of the row belong to pairs (i, jd) with i <= jd
    assign row_mask  = (MAX_VARS'(2) << r_jd) - MAX_VARS'(1);
    assign acc_next  = r_acc ^ (r_pend & r_x[r_jd] & (^(i_rd_data & r_x & row_mask)));
    assign eval_more = (r_j < r_count);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign cfg_count = (CMP_W'(i_cfg_data) > CMP_W'(MAX_VARS)) ? CNT_W'(MAX_VARS)
                                                               : CNT_W'(i_cfg_data);

    always_comb begin
        o_ctl       = '0;
        o_ctl.clear = i_cfg_valid;
        o_rd_addr   = r_hi;
        o_wr_addr   = r_hi;
        o_wr_data   = i_rd_data ^ lo_bit;
        if (r_action == ACT_SET) begin
            o_wr_data = r_tv ? (i_rd_data | lo_bit) : (i_rd_data & ~lo_bit);
        end
        unique case (r_state)
            S_TERM_RD: begin
                o_ctl.rd_en = 1'b1;
            end
            S_TERM_WR: begin
                o_ctl.wr_en = (r_action == ACT_SET) || (r_action == ACT_FLIP);
            end
            S_EVAL: begin
                o_ctl.rd_en = eval_more;
                o_rd_addr   = r_j[AW-1:0];
            end
            S_IDLE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_const     <= 1'b0;
            r_count     <= CNT_W'(RST_COUNT);
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            // in S_DONE the output register is loaded below instead
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_count <= cfg_count;
                r_const <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action <= in_act;
                        r_lo     <= AW'(in_lo);
                        r_hi     <= AW'(in_hi);
                        r_tv     <= i_term_value;
                        r_x      <= MAX_VARS'(i_var_bits);
                        r_res    <= 1'b0;
                        r_ok     <= 1'b1;
                        if (in_act == ACT_EVAL) begin
                            r_acc   <= r_const;
                            r_j     <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_EVAL;
                        end else if (i_const_sel) begin
                            unique case (in_act)
                                ACT_SET:  r_const <= i_term_value;
                                ACT_FLIP: r_const <= ~r_const;
                                ACT_READ: r_res   <= r_const;
                                default: begin
                                end
                            endcase
                            r_state <= S_DONE;
                        end else if (!idx_ok) begin
                            r_ok    <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_TERM_RD;
                        end
                    end
                end
                S_TERM_RD: begin
                    r_state <= S_TERM_WR;
                end
                S_TERM_WR: begin
                    if (r_action == ACT_READ) begin
                        r_res <= i_rd_data[r_lo];
                    end
                    r_state <= S_DONE;
                end
                S_EVAL: begin
                    // row j is read here and folded in on the next cycle
                    r_acc  <= acc_next;
                    r_pend <= eval_more;
                    if (eval_more) begin
                        r_jd <= r_j[AW-1:0];
                        r_j  <= r_j + CNT_W'(1);
                    end else if (!r_pend) begin
                        r_res   <= r_acc;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_res;
                        r_out_ok    <= r_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_result_bit = r_out_res;
    assign o_ok         = r_out_ok;

endmodule

### rtl/gf2_quadratic_form_eval.sv
// Top level of the GF(2) quadratic form evaluator.
// Holds one quadratic polynomial over GF(2): a constant coefficient kept in a flip-flop and
// one coefficient row per variable in a single-port-read memory, where bit i of row j is the
// coefficient of xi*xj (i <= j, diagonal = linear term). Items set, flip or read one
// coefficient, or evaluate the polynomial for a variable assignment. One item is in work at a
// time, and the output register lets the next item enter while a result waits. Constant-term
// and out-of-range items go straight to the result, term items read the memory, then
// modify and write back (set and flip only), and evaluate reads rows 0 to count-1, where
// count is num_vars capped at MAX_VARS: the memory read port delivers one row per cycle,
// each row is folded in the cycle after its read, and a last step closes the sum. A result
// held by a stalled output keeps the item behind it from finishing. Reset and a num_vars
// write clear the store at once through per-row valid bits; there is no clearing pass. The
// configuration port is always ready.
`timescale 1ns / 1ps
module gf2_quadratic_form_eval #(
    parameter int MAX_VARS = qfe_pkg::DEF_MAX_VARS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qfe_pkg::NUM_VARS_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_action,
    input  logic                           i_const_sel,
    input  logic [qfe_pkg::IDX_W-1:0]      i_row_index,
    input  logic [qfe_pkg::IDX_W-1:0]      i_col_index,
    input  logic                           i_term_value,
    input  logic [qfe_pkg::VAR_W-1:0]      i_var_bits,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_result_bit,
    output logic                           o_ok
);
    import qfe_pkg::*;

    localparam int AW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int CNT_W = $clog2(MAX_VARS + 1);

    t_store_ctl          store_ctl;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [MAX_VARS-1:0] wr_data;
    logic [MAX_VARS-1:0] rd_data;

    assign o_cfg_ready = 1'b1;

    qfe_ctrl #(
        .MAX_VARS (MAX_VARS),
        .AW       (AW),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_const_sel  (i_const_sel),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_term_value (i_term_value),
        .i_var_bits   (i_var_bits),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result_bit (o_result_bit),
        .o_ok         (o_ok),
        .o_ctl        (store_ctl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_rd_data    (rd_data)
    );

    qfe_store #(
        .MAX_VARS (MAX_VARS),
        .AW       (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

### rtl/qfe_checker.sv
// Port-level checks for the quadratic form evaluator, bound to the top level.
`timescale 1ns / 1ps
module qfe_port_checks (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_result_bit,
    input logic o_ok
);

    // one item at a time: an accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item was still in work");

    // a new result only appears after an item was in work
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    // an out-of-range item never reports a coefficient
    a_fail_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> !o_result_bit)
        else $error("out-of-range item returned a nonzero bit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_result_bit) && $stable(o_ok)))
        else $error("stalled result changed or dropped");

endmodule

bind gf2_quadratic_form_eval qfe_port_checks u_qfe_port_checks (.*);

### sim/qfe_checker.sv
// Predictor and scoreboard for the GF(2) quadratic form evaluator, fed by the block's ports.
`timescale 1ns / 1ps
module qfe_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [qfe_pkg::NUM_VARS_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [1:0]                     i_action,
    input  logic                           i_const_sel,
    input  logic [qfe_pkg::IDX_W-1:0]      i_row_index,
    input  logic [qfe_pkg::IDX_W-1:0]      i_col_index,
    input  logic                           i_term_value,
    input  logic [qfe_pkg::VAR_W-1:0]      i_var_bits,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_result_bit,
    input  logic                           i_ok,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import qfe_pkg::*;

    localparam int MAXV       = DEF_MAX_VARS;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic result_bit;
        logic ok;
    } t_outcome;

    // row j, bit i: coefficient of xi*xj with i <= j
    logic [VAR_W-1:0]      coef_rows [MAXV];
    logic                  const_coef;
    logic [NUM_VARS_W-1:0] var_count;
    t_outcome              awaited_outcomes [$];
    int                    fails   = 0;
    int                    checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic void clear_coefs();
        for (int j = 0; j < MAXV; j++) begin
            coef_rows[j] = '0;
        end
        const_coef = 1'b0;
    endfunction

    function automatic int active_vars();
        return (var_count > MAXV) ? MAXV : int'(var_count);
    endfunction

    // applies one item to the coefficient store and returns the outcome it should produce
    function automatic t_outcome apply_item(t_action act, logic csel, logic [IDX_W-1:0] r,
                                            logic [IDX_W-1:0] c, logic tv,
                                            logic [VAR_W-1:0] x);
        t_outcome         res;
        int               n;
        int               lo;
        int               hi;
        logic             acc;
        logic [VAR_W-1:0] mask;
        n = active_vars();
        res.result_bit = 1'b0;
        res.ok         = 1'b1;
        if (act == ACT_EVAL) begin
            acc = const_coef;
            for (int j = 0; j < n; j++) begin
                if (x[j]) begin
                    mask = (j == VAR_W - 1) ? '1 : ((VAR_W'(1) << (j + 1)) - 1'b1);
                    acc ^= ^(coef_rows[j] & x & mask);
                end
            end
            res.result_bit = acc;
        end else if (csel) begin
            case (act)
                ACT_SET:  const_coef = tv;
                ACT_FLIP: const_coef = ~const_coef;
                default:  res.result_bit = const_coef;
            endcase
        end else if (r >= n || c >= n) begin
            res.ok = 1'b0;
        end else begin
            lo = (r < c) ? r : c;
            hi = (r < c) ? c : r;
            case (act)
                ACT_SET:  coef_rows[hi][lo] = tv;
                ACT_FLIP: coef_rows[hi][lo] = ~coef_rows[hi][lo];
                default:  res.result_bit = coef_rows[hi][lo];
            endcase
        end
        return res;
    endfunction

    task automatic report_failure(string what);
        fails++;
        if (fails <= MAX_REPORT) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            clear_coefs();
            var_count = NUM_VARS_W'(NUM_VARS_RST);
            awaited_outcomes.delete();
        end else begin
            // results leave before the item accepted at the same edge can have one
            if (i_out_valid && !i_out_stall) begin
                got.result_bit = i_result_bit;
                got.ok         = i_ok;
                checked++;
                if (awaited_outcomes.size() == 0) begin
                    report_failure($sformatf("unexpected result: result_bit=%0d ok=%0d",
                                             got.result_bit, got.ok));
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (got.result_bit !== want.result_bit || got.ok !== want.ok) begin
                        report_failure($sformatf(
                            "mismatch: result_bit exp %0d got %0d, ok exp %0d got %0d",
                            want.result_bit, got.result_bit, want.ok, got.ok));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_outcomes.push_back(apply_item(t_action'(i_action), i_const_sel,
                                                      i_row_index, i_col_index,
                                                      i_term_value, i_var_bits));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                var_count = i_cfg_data;
                clear_coefs();
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_outcomes.size();
        o_checked    <= checked;
    end

endmodule

### sim/gf2_quadratic_form_eval_test.sv
// Top of the GF(2) quadratic form evaluator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module gf2_quadratic_form_eval_test;
    import qfe_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int NUM_PHASES  = 7;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [NUM_VARS_W-1:0] i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic [1:0]            i_action     = ACT_SET;
    logic                  i_const_sel  = 1'b0;
    logic [IDX_W-1:0]      i_row_index  = '0;
    logic [IDX_W-1:0]      i_col_index  = '0;
    logic                  i_term_value = 1'b0;
    logic [VAR_W-1:0]      i_var_bits   = '0;
    logic                  i_out_stall  = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_result_bit;
    logic                  o_ok;

    int fail_count;
    int pending;
    int checked;
    int cycle_count   = 0;
    bit idle_on       = 1'b1;
    int stall_left    = 0;
    int run_left      = 0;
    int active_n      = NUM_VARS_RST;
    int settings_used = 0;
    int action_count [4] = '{0, 0, 0, 0};

    gf2_quadratic_form_eval i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_const_sel  (i_const_sel),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_term_value (i_term_value),
        .i_var_bits   (i_var_bits),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result_bit (o_result_bit),
        .o_ok         (o_ok)
    );

    qfe_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_const_sel  (i_const_sel),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_term_value (i_term_value),
        .i_var_bits   (i_var_bits),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_result_bit (o_result_bit),
        .i_ok         (o_ok),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall bursts between free-running stretches
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
            run_left    <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (run_left != 0) begin
                run_left <= run_left - 1;
            end else if ($urandom_range(0, 2) == 0) begin
                stall_left <= $urandom_range(1, 14);
            end else begin
                run_left <= $urandom_range(1, 30);
            end
        end
    end

    // holds the item until the block takes it; valid stays high for a following item
    task automatic send_item(t_action act, logic csel, logic [IDX_W-1:0] r,
                             logic [IDX_W-1:0] c, logic tv, logic [VAR_W-1:0] x);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_const_sel  <= csel;
        i_row_index  <= r;
        i_col_index  <= c;
        i_term_value <= tv;
        i_var_bits   <= x;
        do @(posedge i_clk); while (o_in_stall);
        action_count[int'(act)]++;
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_num_vars(logic [NUM_VARS_W-1:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_n = (count > DEF_MAX_VARS) ? DEF_MAX_VARS : int'(count);
        settings_used++;
    endtask

    // mostly in-range term updates, reads and evaluations; a few fully random items
    task automatic send_random_item();
        int               roll;
        t_action          act;
        logic             csel;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [VAR_W-1:0] x;
        roll = $urandom_range(0, 99);
        x    = $urandom();
        if (roll < 8) begin
            act  = t_action'($urandom_range(0, 3));
            csel = 1'($urandom_range(0, 1));
            r    = IDX_W'($urandom_range(0, 31));
            c    = IDX_W'($urandom_range(0, 31));
        end else begin
            roll = $urandom_range(0, 99);
            act  = (roll < 30) ? ACT_SET : (roll < 50) ? ACT_FLIP :
                   (roll < 72) ? ACT_READ : ACT_EVAL;
            csel = ($urandom_range(0, 9) == 0);
            if (active_n == 0 || $urandom_range(0, 9) == 0) begin
                r = IDX_W'($urandom_range(0, 31));
                c = IDX_W'($urandom_range(0, 31));
            end else begin
                r = IDX_W'($urandom_range(0, active_n - 1));
                c = ($urandom_range(0, 4) == 0) ? r : IDX_W'($urandom_range(0, active_n - 1));
            end
        end
        case ($urandom_range(0, 9))
            0:       x = '0;
            1:       x = '1;
            default: ;
        endcase
        sender_gap();
        send_item(act, csel, r, c, 1'($urandom_range(0, 1)), x);
    endtask

    task automatic run_directed();
        // reset count of 32: every index valid
        send_item(ACT_READ, 1'b1, 5'd0,  5'd0,  1'b0, '0);    // constant is clear after reset
        send_item(ACT_SET,  1'b1, 5'd31, 5'd7,  1'b1, '0);    // indices ignored for constant
        send_item(ACT_EVAL, 1'b0, 5'd0,  5'd0,  1'b0, '0);
        send_item(ACT_FLIP, 1'b1, 5'd0,  5'd0,  1'b0, '0);
        send_item(ACT_READ, 1'b1, 5'd31, 5'd31, 1'b1, '1);
        send_item(ACT_SET,  1'b0, 5'd0,  5'd0,  1'b1, '0);    // linear x0
        send_item(ACT_SET,  1'b0, 5'd31, 5'd31, 1'b1, '0);    // linear x31
        send_item(ACT_SET,  1'b0, 5'd31, 5'd0,  1'b1, '0);    // x0*x31
        send_item(ACT_READ, 1'b0, 5'd0,  5'd31, 1'b0, '0);    // pair order swapped
        send_item(ACT_EVAL, 1'b0, 5'd0,  5'd0,  1'b0, '1);
        send_item(ACT_EVAL, 1'b1, 5'd31, 5'd3,  1'b0, 32'h8000_0001);
        send_item(ACT_FLIP, 1'b0, 5'd17, 5'd5,  1'b0, '0);
        send_item(ACT_READ, 1'b0, 5'd5,  5'd17, 1'b0, '0);
        send_item(ACT_SET,  1'b0, 5'd0,  5'd31, 1'b0, '1);    // set with zero clears the term
        send_item(ACT_EVAL, 1'b0, 5'd0,  5'd0,  1'b0, 32'h0002_0021);
        wait_drained();
        write_num_vars(6'd5);
        send_item(ACT_SET,  1'b0, 5'd5,  5'd0,  1'b1, '0);    // out of range
        send_item(ACT_READ, 1'b0, 5'd31, 5'd31, 1'b0, '0);
        send_item(ACT_FLIP, 1'b0, 5'd4,  5'd4,  1'b0, '0);
        send_item(ACT_FLIP, 1'b1, 5'd31, 5'd31, 1'b0, '0);
        send_item(ACT_EVAL, 1'b0, 5'd0,  5'd0,  1'b0, '1);
        wait_drained();
        write_num_vars(6'd0);                                 // no pair is valid
        send_item(ACT_READ, 1'b0, 5'd0,  5'd0,  1'b0, '0);
        send_item(ACT_SET,  1'b1, 5'd0,  5'd0,  1'b1, '0);
        send_item(ACT_EVAL, 1'b0, 5'd0,  5'd0,  1'b0, '1);
        wait_drained();
        write_num_vars(6'd63);                                // capped at the full range
        send_item(ACT_SET,  1'b0, 5'd31, 5'd30, 1'b1, '0);
        send_item(ACT_EVAL, 1'b0, 5'd0,  5'd0,  1'b0, 32'hC000_0000);
    endtask

    initial begin
        logic [NUM_VARS_W-1:0] phase_vars  [NUM_PHASES];
        int                    phase_items [NUM_PHASES];
        phase_vars  = '{6'd32, 6'd1, 6'd63, 6'd0, 6'($urandom_range(2, 31)), 6'd17, 6'd32};
        phase_items = '{90, 70, 80, 30, 90, 80, 90};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            if (p == NUM_PHASES - 1) begin
                idle_on <= 1'b0;
            end
            write_num_vars(phase_vars[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                // sender holds off mid-phase until the block has emptied
                if (k == phase_items[p] / 2) begin
                    wait_drained();
                end
                send_random_item();
            end
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d set, %0d flip, %0d read, %0d evaluate items", action_count[0],
                 action_count[1], action_count[2], action_count[3]);
        $display("over %0d num_vars settings; %0d results checked, %0d failures",
                 settings_used, checked, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/qfe_pkg.sv
rtl/qfe_store.sv
rtl/qfe_ctrl.sv
rtl/gf2_quadratic_form_eval.sv
rtl/qfe_checker.sv
sim/qfe_checker.sv
sim/gf2_quadratic_form_eval_test.sv
